// ===== hw/rtl/dmbm_pkg.sv =====
// Display mode best match: shared widths, register indexes and the config type.
// No dependencies; the interfaces, the register file, the top level and the testbench use it.
`timescale 1ns / 1ps
`default_nettype none

package dmbm_pkg;

   localparam int WIDTH_W   = 14;
   localparam int REFRESH_W = 20;
   localparam int PIX_W     = 2 * WIDTH_W;
   localparam int ADDR_W    = 4;
   localparam int IDX_W     = 2;
   localparam int DATA_W    = 32;

   localparam logic [IDX_W-1:0] REG_TARGET_WIDTH   = 2'd0;
   localparam logic [IDX_W-1:0] REG_TARGET_HEIGHT  = 2'd1;
   localparam logic [IDX_W-1:0] REG_TARGET_REFRESH = 2'd2;
   localparam logic [IDX_W-1:0] REG_REFRESH_GIVEN  = 2'd3;

   localparam logic [WIDTH_W-1:0]   RST_TARGET_WIDTH   = 14'd1920;
   localparam logic [WIDTH_W-1:0]   RST_TARGET_HEIGHT  = 14'd1080;
   localparam logic [REFRESH_W-1:0] RST_TARGET_REFRESH = 20'd60000;

   typedef struct packed {
      logic [WIDTH_W-1:0]   target_width;
      logic [WIDTH_W-1:0]   target_height;
      logic [REFRESH_W-1:0] target_refresh;
      logic                 refresh_given;
   } cfg_type;

endpackage

`default_nettype wire

// ===== hw/rtl/dmbm_if.sv =====
// Display mode best match: valid/ready channels for mode items and result items.
// Depends on dmbm_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface dmbm_req_if;
   logic                            valid;
   logic                            ready;
   logic [dmbm_pkg::WIDTH_W-1:0]    mode_width;
   logic [dmbm_pkg::WIDTH_W-1:0]    mode_height;
   logic [dmbm_pkg::REFRESH_W-1:0]  mode_refresh;
   logic                            last_mode;

   modport source (output valid, mode_width, mode_height, mode_refresh, last_mode,
                   input ready);
   modport sink (input valid, mode_width, mode_height, mode_refresh, last_mode,
                 output ready);
endinterface

interface dmbm_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [dmbm_pkg::WIDTH_W-1:0]    chosen_width;
   logic [dmbm_pkg::WIDTH_W-1:0]    chosen_height;
   logic [dmbm_pkg::REFRESH_W-1:0]  chosen_refresh;
   logic                            found;

   modport source (output valid, chosen_width, chosen_height, chosen_refresh, found,
                   input ready);
   modport sink (input valid, chosen_width, chosen_height, chosen_refresh, found,
                 output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dmbm_div.sv =====
// Display mode best match: restoring divider, one quotient bit per cycle.
// Standalone; used by display_mode_best_match for the aspect ratios.
`timescale 1ns / 1ps
`default_nettype none

module dmbm_div #(
   parameter int N  = 30,
   parameter int DW = 14
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start_i,
   input  wire logic [N-1:0]  dividend_i,
   input  wire logic [DW-1:0] divisor_i,
   output logic               done_o,
   output logic [N-1:0]       quot_o
);

   localparam int CW = $clog2(N + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [N-1:0]  dvd_ff, dvd_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] dsr_ff, dsr_in;
   logic [DW:0]   trial;
   logic          ge;

   assign trial = {rem_ff, dvd_ff[N-1]};
   assign ge    = trial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      done_in = busy_ff && (cnt_ff == CW'(1));
      if (start_i) begin
         busy_in = 1'b1;
         cnt_in  = CW'(N);
         dvd_in  = dividend_i;
         rem_in  = '0;
         dsr_in  = divisor_i;
      end else if (busy_ff) begin
         rem_in  = ge ? DW'(trial - {1'b0, dsr_ff}) : trial[DW-1:0];
         dvd_in  = {dvd_ff[N-2:0], ge};
         cnt_in  = cnt_ff - CW'(1);
         busy_in = cnt_ff != CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done_o = done_ff;
   assign quot_o = dvd_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/dmbm_csr.sv =====
// Display mode best match: APB target registers.
// Depends on dmbm_pkg for the register indexes and cfg_type.
`timescale 1ns / 1ps
`default_nettype none

module dmbm_csr (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [dmbm_pkg::ADDR_W-1:0] paddr,
   input  wire logic [dmbm_pkg::DATA_W-1:0] pwdata,
   output logic [dmbm_pkg::DATA_W-1:0]      prdata,
   output logic                             pready,
   output dmbm_pkg::cfg_type                cfg_o,
   output logic                             geom_wr_o
);

   dmbm_pkg::cfg_type               cfg_ff, cfg_in;
   logic                            wr;
   logic [dmbm_pkg::IDX_W-1:0]      idx;

   assign wr     = psel && penable && pwrite;
   assign idx    = paddr[dmbm_pkg::ADDR_W-1:2];
   assign pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            dmbm_pkg::REG_TARGET_WIDTH:   cfg_in.target_width =
                                             pwdata[dmbm_pkg::WIDTH_W-1:0];
            dmbm_pkg::REG_TARGET_HEIGHT:  cfg_in.target_height =
                                             pwdata[dmbm_pkg::WIDTH_W-1:0];
            dmbm_pkg::REG_TARGET_REFRESH: cfg_in.target_refresh =
                                             pwdata[dmbm_pkg::REFRESH_W-1:0];
            dmbm_pkg::REG_REFRESH_GIVEN:  cfg_in.refresh_given = pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_width   <= dmbm_pkg::RST_TARGET_WIDTH;
         cfg_ff.target_height  <= dmbm_pkg::RST_TARGET_HEIGHT;
         cfg_ff.target_refresh <= dmbm_pkg::RST_TARGET_REFRESH;
         cfg_ff.refresh_given  <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (idx)
         dmbm_pkg::REG_TARGET_WIDTH:   prdata = dmbm_pkg::DATA_W'(cfg_ff.target_width);
         dmbm_pkg::REG_TARGET_HEIGHT:  prdata = dmbm_pkg::DATA_W'(cfg_ff.target_height);
         dmbm_pkg::REG_TARGET_REFRESH: prdata = dmbm_pkg::DATA_W'(cfg_ff.target_refresh);
         dmbm_pkg::REG_REFRESH_GIVEN:  prdata = dmbm_pkg::DATA_W'(cfg_ff.refresh_given);
         default:                      prdata = '0;
      endcase
   end

   assign cfg_o     = cfg_ff;
   assign geom_wr_o = wr && (idx == dmbm_pkg::REG_TARGET_WIDTH ||
                             idx == dmbm_pkg::REG_TARGET_HEIGHT);

endmodule

`default_nettype wire

// ===== hw/rtl/display_mode_best_match.sv =====
// Display mode best match: top level, sequencer around one shared divider.
// Depends on dmbm_pkg, dmbm_if, dmbm_div and dmbm_csr.
//
//  channel   dir  handshake       payload
//  req_chan  in   valid/ready     mode_width, mode_height, mode_refresh, last_mode
//  rsp_chan  out  valid/ready     chosen_width, chosen_height, chosen_refresh, found
//  csr_*     in   APB write/read  target_width, target_height, target_refresh,
//                                 refresh_given
//
// An offered mode passes LOAD, MDIV (bit-serial divider), GAP, CMP and DONE;
// the first nonzero-sized mode after reset or a target size write first runs TDIV
// for the target ratio (not with a zero target height). Zero-sized modes skip to DONE.
// Reset is synchronous; it clears the held mode and marks the target ratio stale.
// A held result does not block new items; only a following last item waits for it.
`timescale 1ns / 1ps
`default_nettype none

module display_mode_best_match #(
   parameter int RATIO_FRAC_BITS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   dmbm_req_if.sink                         req_chan,
   dmbm_rsp_if.source                       rsp_chan,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [dmbm_pkg::ADDR_W-1:0] csr_paddr,
   input  wire logic [dmbm_pkg::DATA_W-1:0] csr_pwdata,
   output logic [dmbm_pkg::DATA_W-1:0]      csr_prdata,
   output logic                             csr_pready
);

   localparam int WW = dmbm_pkg::WIDTH_W;
   localparam int FW = dmbm_pkg::REFRESH_W;
   localparam int PW = dmbm_pkg::PIX_W;
   localparam int RW = WW + RATIO_FRAC_BITS;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_LOAD = 3'd1;
   localparam logic [2:0] S_TDIV = 3'd2;
   localparam logic [2:0] S_MDIV = 3'd3;
   localparam logic [2:0] S_GAP  = 3'd4;
   localparam logic [2:0] S_CMP  = 3'd5;
   localparam logic [2:0] S_DONE = 3'd6;

   dmbm_pkg::cfg_type cfg;
   logic              geom_wr;

   logic [2:0]    state_ff, state_in;
   logic [WW-1:0] w_ff, w_in, h_ff, h_in;
   logic [FW-1:0] r_ff, r_in;
   logic          last_ff, last_in;
   logic          dirty_ff, dirty_in;
   logic [RW-1:0] tratio_ff, tratio_in, mratio_ff, mratio_in;
   logic [PW-1:0] tpix_ff, tpix_in, mpix_ff, mpix_in;
   logic [RW-1:0] rg_ff, rg_in;
   logic [PW-1:0] pg_ff, pg_in;
   logic [FW-1:0] fg_ff, fg_in;

   logic          have_ff, have_in;
   logic [WW-1:0] bw_ff, bw_in, bh_ff, bh_in;
   logic [FW-1:0] br_ff, br_in;
   logic [PW-1:0] bpix_ff, bpix_in;
   logic [RW-1:0] brg_ff, brg_in;
   logic [PW-1:0] bpg_ff, bpg_in;
   logic [FW-1:0] bfg_ff, bfg_in;

   logic          ovalid_ff, ovalid_in;
   logic [WW-1:0] ow_ff, ow_in, oh_ff, oh_in;
   logic [FW-1:0] or_ff, or_in;
   logic          ofound_ff, ofound_in;

   logic [WW-1:0] mul_a, mul_b;
   logic [PW-1:0] prod;
   logic          div_start, div_done;
   logic [RW-1:0] div_dvd, div_quot;
   logic [WW-1:0] div_dsr;
   logic          tdiv_sel, accept, out_free, emit, take, skip;

   dmbm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (csr_psel),
      .penable   (csr_penable),
      .pwrite    (csr_pwrite),
      .paddr     (csr_paddr),
      .pwdata    (csr_pwdata),
      .prdata    (csr_prdata),
      .pready    (csr_pready),
      .cfg_o     (cfg),
      .geom_wr_o (geom_wr)
   );

   dmbm_div #(.N(RW), .DW(WW)) u_div (
      .clock      (clock),
      .reset      (reset),
      .start_i    (div_start),
      .dividend_i (div_dvd),
      .divisor_i  (div_dsr),
      .done_o     (div_done),
      .quot_o     (div_quot)
   );

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !ovalid_ff || rsp_chan.ready;
   assign emit     = (state_ff == S_DONE) && last_ff && out_free;
   assign skip     = (w_ff == '0) || (h_ff == '0);
   assign tdiv_sel = (state_ff == S_LOAD) && dirty_ff && (cfg.target_height != '0);

   assign mul_a = (state_ff == S_LOAD) ? cfg.target_width  : w_ff;
   assign mul_b = (state_ff == S_LOAD) ? cfg.target_height : h_ff;
   assign prod  = mul_a * mul_b;

   assign div_dvd = tdiv_sel ? {cfg.target_width, {RATIO_FRAC_BITS{1'b0}}}
                             : {w_ff, {RATIO_FRAC_BITS{1'b0}}};
   assign div_dsr = tdiv_sel ? cfg.target_height : h_ff;

   always_comb begin
      take = 1'b0;
      if (!have_ff)
         take = 1'b1;
      else if (rg_ff != brg_ff)
         take = rg_ff < brg_ff;
      else if (pg_ff != bpg_ff)
         take = pg_ff < bpg_ff;
      else if (cfg.refresh_given && fg_ff != bfg_ff)
         take = fg_ff < bfg_ff;
      else if (mpix_ff != bpix_ff)
         take = mpix_ff > bpix_ff;
      else
         take = r_ff > br_ff;
   end

   always_comb begin
      state_in  = state_ff;
      w_in      = w_ff;
      h_in      = h_ff;
      r_in      = r_ff;
      last_in   = last_ff;
      dirty_in  = dirty_ff;
      tratio_in = tratio_ff;
      mratio_in = mratio_ff;
      tpix_in   = tpix_ff;
      mpix_in   = mpix_ff;
      rg_in     = rg_ff;
      pg_in     = pg_ff;
      fg_in     = fg_ff;
      have_in   = have_ff;
      bw_in     = bw_ff;
      bh_in     = bh_ff;
      br_in     = br_ff;
      bpix_in   = bpix_ff;
      brg_in    = brg_ff;
      bpg_in    = bpg_ff;
      bfg_in    = bfg_ff;
      ovalid_in = ovalid_ff && !rsp_chan.ready;
      ow_in     = ow_ff;
      oh_in     = oh_ff;
      or_in     = or_ff;
      ofound_in = ofound_ff;
      div_start = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               w_in     = req_chan.mode_width;
               h_in     = req_chan.mode_height;
               r_in     = req_chan.mode_refresh;
               last_in  = req_chan.last_mode;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            if (skip) begin
               state_in = S_DONE;
            end else if (tdiv_sel) begin
               tpix_in   = prod;
               div_start = 1'b1;
               state_in  = S_TDIV;
            end else begin
               if (dirty_ff) begin
                  tpix_in   = prod;
                  tratio_in = {RW{1'b1}};
                  dirty_in  = 1'b0;
               end
               div_start = 1'b1;
               state_in  = S_MDIV;
            end
         end
         S_TDIV: begin
            if (div_done) begin
               tratio_in = div_quot;
               dirty_in  = 1'b0;
               div_start = 1'b1;
               state_in  = S_MDIV;
            end
         end
         S_MDIV: begin
            mpix_in = prod;
            if (div_done) begin
               mratio_in = div_quot;
               state_in  = S_GAP;
            end
         end
         S_GAP: begin
            rg_in = (mratio_ff > tratio_ff) ? mratio_ff - tratio_ff : tratio_ff - mratio_ff;
            pg_in = (mpix_ff > tpix_ff) ? mpix_ff - tpix_ff : tpix_ff - mpix_ff;
            if (!cfg.refresh_given)
               fg_in = '0;
            else if (r_ff > cfg.target_refresh)
               fg_in = r_ff - cfg.target_refresh;
            else
               fg_in = cfg.target_refresh - r_ff;
            state_in = S_CMP;
         end
         S_CMP: begin
            if (take) begin
               have_in = 1'b1;
               bw_in   = w_ff;
               bh_in   = h_ff;
               br_in   = r_ff;
               bpix_in = mpix_ff;
               brg_in  = rg_ff;
               bpg_in  = pg_ff;
               bfg_in  = fg_ff;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!last_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               ovalid_in = 1'b1;
               ofound_in = have_ff;
               ow_in     = have_ff ? bw_ff : '0;
               oh_in     = have_ff ? bh_ff : '0;
               or_in     = have_ff ? br_ff : '0;
               have_in   = 1'b0;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (geom_wr)
         dirty_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         dirty_ff  <= 1'b1;
         have_ff   <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         dirty_ff  <= dirty_in;
         have_ff   <= have_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff      <= w_in;
      h_ff      <= h_in;
      r_ff      <= r_in;
      last_ff   <= last_in;
      tratio_ff <= tratio_in;
      mratio_ff <= mratio_in;
      tpix_ff   <= tpix_in;
      mpix_ff   <= mpix_in;
      rg_ff     <= rg_in;
      pg_ff     <= pg_in;
      fg_ff     <= fg_in;
      bw_ff     <= bw_in;
      bh_ff     <= bh_in;
      br_ff     <= br_in;
      bpix_ff   <= bpix_in;
      brg_ff    <= brg_in;
      bpg_ff    <= bpg_in;
      bfg_ff    <= bfg_in;
      ow_ff     <= ow_in;
      oh_ff     <= oh_in;
      or_ff     <= or_in;
      ofound_ff <= ofound_in;
   end

   assign req_chan.ready          = state_ff == S_IDLE;
   assign rsp_chan.valid          = ovalid_ff;
   assign rsp_chan.chosen_width   = ow_ff;
   assign rsp_chan.chosen_height  = oh_ff;
   assign rsp_chan.chosen_refresh = or_ff;
   assign rsp_chan.found          = ofound_ff;

   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_TDIV || state_ff == S_MDIV))
      else $error("divider finished outside a divide wait");

   a_emit_clears_best: assert property (@(posedge clock) disable iff (reset)
      emit |=> !have_ff && ovalid_ff)
      else $error("result emitted without clearing held mode");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (ovalid_ff && !ofound_ff) |->
         (ow_ff == '0 && oh_ff == '0 && or_ff == '0))
      else $error("empty list result carries a mode");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (ovalid_ff && !rsp_chan.ready) |=> ovalid_ff && $stable(ow_ff) && $stable(or_ff))
      else $error("pending result lost");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Testbench for display_mode_best_match: directed table then random mode lists.
// Checks results against a best-match predictor or a typed result; uses dmbm_pkg, dmbm_if.
`timescale 1ns / 1ps

module testbench;

   localparam int WIDTH_W   = dmbm_pkg::WIDTH_W;
   localparam int REFRESH_W = dmbm_pkg::REFRESH_W;
   localparam int PIX_W     = dmbm_pkg::PIX_W;
   localparam int ADDR_W    = dmbm_pkg::ADDR_W;
   localparam int IDX_W     = dmbm_pkg::IDX_W;
   localparam int DATA_W    = dmbm_pkg::DATA_W;

   localparam logic [IDX_W-1:0] REG_TARGET_WIDTH   = dmbm_pkg::REG_TARGET_WIDTH;
   localparam logic [IDX_W-1:0] REG_TARGET_HEIGHT  = dmbm_pkg::REG_TARGET_HEIGHT;
   localparam logic [IDX_W-1:0] REG_TARGET_REFRESH = dmbm_pkg::REG_TARGET_REFRESH;
   localparam logic [IDX_W-1:0] REG_REFRESH_GIVEN  = dmbm_pkg::REG_REFRESH_GIVEN;

   localparam logic [WIDTH_W-1:0]   RST_TARGET_WIDTH   = dmbm_pkg::RST_TARGET_WIDTH;
   localparam logic [WIDTH_W-1:0]   RST_TARGET_HEIGHT  = dmbm_pkg::RST_TARGET_HEIGHT;
   localparam logic [REFRESH_W-1:0] RST_TARGET_REFRESH = dmbm_pkg::RST_TARGET_REFRESH;

   localparam int FRAC_BITS    = 16;
   localparam int RATIO_W      = WIDTH_W + FRAC_BITS;
   localparam int DRAIN_CYCLES = 150;
   localparam int LONG_HOLD    = 600;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int SEG_ITEMS    = 190;

   typedef struct packed {
      logic [WIDTH_W-1:0]   width;
      logic [WIDTH_W-1:0]   height;
      logic [REFRESH_W-1:0] refresh;
      logic                 last;
   } mode_type;

   typedef struct packed {
      logic [WIDTH_W-1:0]   width;
      logic [WIDTH_W-1:0]   height;
      logic [REFRESH_W-1:0] refresh;
      logic                 found;
   } result_type;

   typedef enum {ROW_MODE, ROW_WRITE} row_kind_type;

   typedef struct {
      row_kind_type     kind;
      mode_type         mode;
      logic [IDX_W-1:0] reg_idx;
      logic [31:0]      value;
      bit               typed;
      result_type       result;
   } row_type;

   logic clock;
   logic reset;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [ADDR_W-1:0] csr_paddr;
   logic [DATA_W-1:0] csr_pwdata;
   logic [DATA_W-1:0] csr_prdata;
   logic              csr_pready;

   dmbm_req_if req_chan ();
   dmbm_rsp_if rsp_chan ();

   display_mode_best_match #(.RATIO_FRAC_BITS(FRAC_BITS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // target mirror
   logic [WIDTH_W-1:0]   tgt_width;
   logic [WIDTH_W-1:0]   tgt_height;
   logic [REFRESH_W-1:0] tgt_refresh;
   logic                 tgt_given;

   // held best mode
   bit                   have_held;
   logic [WIDTH_W-1:0]   held_width;
   logic [WIDTH_W-1:0]   held_height;
   logic [REFRESH_W-1:0] held_refresh;
   logic [RATIO_W-1:0]   held_ratio_gap;
   logic [PIX_W-1:0]     held_pixel_gap;
   logic [REFRESH_W-1:0] held_refresh_gap;

   result_type chosen_q[$];
   row_type    dir_rows[$];

   int error_count     = 0;
   int items_accepted  = 0;
   int lists_closed    = 0;
   int results_checked = 0;
   int writes_done     = 0;
   int send_idle_pct   = 0;
   int recv_stall_pct  = 0;
   bit hold_phase      = 0;
   int hold_count      = 0;
   int cycle_count     = 0;

   logic [WIDTH_W-1:0]   std_w [0:11] = '{640, 800, 1024, 1280, 1280, 1366, 1600, 1920, 1920,
                                          2560, 3840, 2560};
   logic [WIDTH_W-1:0]   std_h [0:11] = '{480, 600, 768, 720, 1024, 768, 900, 1080, 1200,
                                          1440, 2160, 1080};
   logic [REFRESH_W-1:0] std_r [0:6]  = '{59940, 60000, 75000, 120000, 144000, 50000, 0};

   task automatic report(input string msg);
      error_count++;
      $display("mismatch: %s", msg);
   endtask

   function automatic logic [RATIO_W-1:0] aspect_of(logic [WIDTH_W-1:0] w,
                                                     logic [WIDTH_W-1:0] h);
      logic [RATIO_W-1:0] scaled;
      if (h == '0) return '1;
      scaled = {w, {FRAC_BITS{1'b0}}};
      return scaled / RATIO_W'(h);
   endfunction

   function automatic longint unsigned abs_diff(longint unsigned a, longint unsigned b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic void clear_held();
      have_held        = 0;
      held_width       = '0;
      held_height      = '0;
      held_refresh     = '0;
      held_ratio_gap   = '0;
      held_pixel_gap   = '0;
      held_refresh_gap = '0;
   endfunction

   task automatic choose_mode(input mode_type m, output bit emits, output result_type res);
      logic [RATIO_W-1:0]   rg;
      logic [PIX_W-1:0]     pg;
      logic [PIX_W-1:0]     cand_pix;
      logic [PIX_W-1:0]     held_pix;
      logic [REFRESH_W-1:0] fg;
      bit                   take;
      if (m.width != '0 && m.height != '0) begin
         rg       = RATIO_W'(abs_diff(aspect_of(m.width, m.height),
                                      aspect_of(tgt_width, tgt_height)));
         cand_pix = PIX_W'(m.width) * PIX_W'(m.height);
         held_pix = PIX_W'(held_width) * PIX_W'(held_height);
         pg       = PIX_W'(abs_diff(cand_pix, PIX_W'(tgt_width) * PIX_W'(tgt_height)));
         fg       = tgt_given ? REFRESH_W'(abs_diff(m.refresh, tgt_refresh)) : '0;
         if (!have_held) begin
            take = 1;
         end else if (rg != held_ratio_gap) begin
            take = rg < held_ratio_gap;
         end else if (pg != held_pixel_gap) begin
            take = pg < held_pixel_gap;
         end else if (tgt_given && fg != held_refresh_gap) begin
            take = fg < held_refresh_gap;
         end else if (cand_pix != held_pix) begin
            take = cand_pix > held_pix;
         end else begin
            take = m.refresh > held_refresh;
         end
         if (take) begin
            have_held        = 1;
            held_width       = m.width;
            held_height      = m.height;
            held_refresh     = m.refresh;
            held_ratio_gap   = rg;
            held_pixel_gap   = pg;
            held_refresh_gap = fg;
         end
      end
      emits = m.last;
      res   = '0;
      if (m.last) begin
         if (have_held) res = '{held_width, held_height, held_refresh, 1'b1};
         clear_held();
      end
   endtask

   function automatic void set_target(logic [IDX_W-1:0] idx, logic [31:0] value);
      case (idx)
         REG_TARGET_WIDTH:   tgt_width   = value[WIDTH_W-1:0];
         REG_TARGET_HEIGHT:  tgt_height  = value[WIDTH_W-1:0];
         REG_TARGET_REFRESH: tgt_refresh = value[REFRESH_W-1:0];
         REG_REFRESH_GIVEN:  tgt_given   = value[0];
         default: ;
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] target_reg(logic [IDX_W-1:0] idx);
      case (idx)
         REG_TARGET_WIDTH:   return DATA_W'(tgt_width);
         REG_TARGET_HEIGHT:  return DATA_W'(tgt_height);
         REG_TARGET_REFRESH: return DATA_W'(tgt_refresh);
         default:            return DATA_W'(tgt_given);
      endcase
   endfunction

   // write, then read back the same register; ends idle with psel low
   task automatic csr_write(input logic [IDX_W-1:0] idx, input logic [31:0] value);
      logic [DATA_W-1:0] readback;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      set_target(idx, value);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      writes_done++;
      if (readback !== target_reg(idx))
         report($sformatf("register %0d read %0h, wrote %0h", idx, readback,
                          target_reg(idx)));
      @(posedge clock);
   endtask

   task automatic offer_mode(input mode_type m, input bit typed, input result_type typed_res);
      bit         emits;
      result_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.mode_width   <= m.width;
      req_chan.mode_height  <= m.height;
      req_chan.mode_refresh <= m.refresh;
      req_chan.last_mode    <= m.last;
      do @(posedge clock); while (!req_chan.ready);
      items_accepted++;
      choose_mode(m, emits, res);
      if (emits) begin
         lists_closed++;
         chosen_q.push_back(typed ? typed_res : res);
      end
   endtask

   // block idle: no result pending and the last item worked off
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (chosen_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic apply_targets(input logic [WIDTH_W-1:0] w, input logic [WIDTH_W-1:0] h,
                                input logic [REFRESH_W-1:0] r, input logic g);
      settle();
      csr_write(REG_TARGET_WIDTH, 32'(w));
      csr_write(REG_TARGET_HEIGHT, 32'(h));
      csr_write(REG_TARGET_REFRESH, 32'(r));
      csr_write(REG_REFRESH_GIVEN, 32'(g));
   endtask

   function automatic row_type mode_row(int w, int h, int r, bit last);
      row_type row;
      row.kind    = ROW_MODE;
      row.mode    = '{WIDTH_W'(w), WIDTH_W'(h), REFRESH_W'(r), last};
      row.reg_idx = '0;
      row.value   = '0;
      row.typed   = 0;
      row.result  = '0;
      return row;
   endfunction

   function automatic row_type typed_row(int w, int h, int r, bit last, result_type res);
      row_type row;
      row        = mode_row(w, h, r, last);
      row.typed  = 1;
      row.result = res;
      return row;
   endfunction

   function automatic row_type write_row(logic [IDX_W-1:0] idx, logic [31:0] value);
      row_type row;
      row         = mode_row(0, 0, 0, 0);
      row.kind    = ROW_WRITE;
      row.reg_idx = idx;
      row.value   = value;
      return row;
   endfunction

   function automatic mode_type random_mode(mode_type prev);
      mode_type    m;
      int unsigned pick;
      int unsigned k;
      pick      = $urandom_range(99);
      k         = $urandom_range(11);
      m.width   = std_w[k];
      m.height  = std_h[k];
      m.refresh = std_r[$urandom_range(6)];
      m.last    = 1'b0;
      if (pick < 20 && prev.width != '0 && prev.height != '0) begin
         m.width  = prev.width;
         m.height = prev.height;
         if ($urandom_range(1)) m.refresh = prev.refresh;
      end else if (pick < 45) begin
         m.width   = WIDTH_W'($urandom_range(1, 9999));
         m.height  = WIDTH_W'($urandom_range(1, 9999));
         m.refresh = REFRESH_W'($urandom_range(0, 999999));
      end else if (pick < 55) begin
         m.width   = WIDTH_W'($urandom);
         m.height  = WIDTH_W'($urandom);
         m.refresh = REFRESH_W'($urandom);
      end else if (pick < 60) begin
         if ($urandom_range(1)) m.width = '0;
         else m.height = '0;
      end
      return m;
   endfunction

   task automatic run_lists(input int target_items);
      int       offered;
      int       len;
      mode_type m;
      mode_type prev;
      offered = 0;
      while (offered < target_items) begin
         len  = $urandom_range(1, 6);
         prev = '0;
         for (int j = 0; j < len; j++) begin
            m = random_mode(prev);
            if (j == len - 1) begin
               m.last = 1'b1;
               if ($urandom_range(99) < 8) m.width = '0;
            end
            offer_mode(m, 0, '0);
            if (m.width != '0 && m.height != '0) offered++;
            prev = m;
         end
      end
   endtask

   // receiver: random stalls plus one long hold-off
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_phase && hold_count < LONG_HOLD) begin
            hold_count++;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (chosen_q.size() == 0) begin
            report("result item with nothing expected");
         end else begin
            want = chosen_q.pop_front();
            results_checked++;
            if (rsp_chan.chosen_width !== want.width)
               report($sformatf("chosen_width %0d, expected %0d",
                                rsp_chan.chosen_width, want.width));
            if (rsp_chan.chosen_height !== want.height)
               report($sformatf("chosen_height %0d, expected %0d",
                                rsp_chan.chosen_height, want.height));
            if (rsp_chan.chosen_refresh !== want.refresh)
               report($sformatf("chosen_refresh %0d, expected %0d",
                                rsp_chan.chosen_refresh, want.refresh));
            if (rsp_chan.found !== want.found)
               report($sformatf("found %0b, expected %0b", rsp_chan.found, want.found));
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("testbench failed");
      $finish;
   end

   initial begin : stimulus
      int                   k;
      logic [WIDTH_W-1:0]   tw;
      logic [WIDTH_W-1:0]   th;
      logic [REFRESH_W-1:0] tr;
      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.mode_width   = '0;
      req_chan.mode_height  = '0;
      req_chan.mode_refresh = '0;
      req_chan.last_mode    = 1'b0;
      csr_psel              = 1'b0;
      csr_penable           = 1'b0;
      csr_pwrite            = 1'b0;
      csr_paddr             = '0;
      csr_pwdata            = '0;
      tgt_width             = RST_TARGET_WIDTH;
      tgt_height            = RST_TARGET_HEIGHT;
      tgt_refresh           = RST_TARGET_REFRESH;
      tgt_given             = 1'b0;
      clear_held();

      dir_rows.push_back(typed_row(1920, 1080, 60000, 1, result_type'{14'd1920, 14'd1080,
                                                                    20'd60000, 1'b1}));
      // zero-sized mode alone: empty list
      dir_rows.push_back(typed_row(0, 1080, 60000, 1, result_type'('0)));
      dir_rows.push_back(mode_row(1280, 0, 60000, 0));
      dir_rows.push_back(typed_row(16383, 16383, 20'hFFFFF, 1,
                                   result_type'{14'h3FFF, 14'h3FFF, 20'hFFFFF, 1'b1}));
      dir_rows.push_back(mode_row(1280, 720, 60000, 0));
      dir_rows.push_back(mode_row(1920, 1080, 59940, 0));
      dir_rows.push_back(mode_row(1920, 1080, 75000, 1));
      dir_rows.push_back(mode_row(1, 1, 0, 0));
      dir_rows.push_back(mode_row(9999, 9999, 999999, 1));
      dir_rows.push_back(write_row(REG_REFRESH_GIVEN, 1));
      dir_rows.push_back(write_row(REG_TARGET_REFRESH, 0));
      dir_rows.push_back(mode_row(1920, 1080, 144000, 0));
      dir_rows.push_back(mode_row(1920, 1080, 50000, 0));
      dir_rows.push_back(mode_row(3840, 2160, 50000, 1));
      // zero target height saturates the target ratio
      dir_rows.push_back(write_row(REG_TARGET_WIDTH, 9999));
      dir_rows.push_back(write_row(REG_TARGET_HEIGHT, 0));
      dir_rows.push_back(mode_row(9999, 1, 0, 0));
      dir_rows.push_back(mode_row(1, 9999, 999999, 1));
      // targets change while a mode is held
      dir_rows.push_back(mode_row(1024, 768, 60000, 0));
      dir_rows.push_back(write_row(REG_TARGET_WIDTH, 1024));
      dir_rows.push_back(write_row(REG_TARGET_HEIGHT, 768));
      dir_rows.push_back(mode_row(800, 600, 60000, 1));
      dir_rows.push_back(write_row(REG_TARGET_REFRESH, 32'hFFFF_FFFF));
      dir_rows.push_back(mode_row(640, 480, 20'hFFFFF, 0));
      dir_rows.push_back(mode_row(640, 480, 999999, 1));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         case (dir_rows[i].kind)
            ROW_MODE: begin
               offer_mode(dir_rows[i].mode, dir_rows[i].typed, dir_rows[i].result);
            end
            ROW_WRITE: begin
               settle();
               csr_write(dir_rows[i].reg_idx, dir_rows[i].value);
            end
            default: ;
         endcase
      end

      for (int s = 0; s < 8; s++) begin
         case (s % 4)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 56;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 56;
            end
            default: begin
               send_idle_pct  = 19;
               recv_stall_pct = 19;
            end
         endcase
         case (s)
            0: apply_targets(RST_TARGET_WIDTH, RST_TARGET_HEIGHT, RST_TARGET_REFRESH, 1'b0);
            1: apply_targets(1, 1, 0, 1'b1);
            2: apply_targets(9999, 9999, 999999, 1'b1);
            default: begin
               k  = $urandom_range(11);
               tw = std_w[k];
               th = std_h[k];
               tr = std_r[$urandom_range(6)];
               if ($urandom_range(1)) begin
                  tw = WIDTH_W'($urandom_range(1, 9999));
                  th = WIDTH_W'($urandom_range(1, 9999));
                  tr = REFRESH_W'($urandom_range(0, 999999));
               end
               apply_targets(tw, th, tr, (s == 3) ? 1'b1 : 1'($urandom_range(1)));
            end
         endcase
         if (s == 4) hold_phase = 1;
         run_lists(SEG_ITEMS);
      end

      settle();
      $display("covered %0d mode items in %0d lists, %0d results checked, %0d csr writes",
               items_accepted, lists_closed, results_checked, writes_done);
      $display("targets swept from 1x1 to 9999x9999, refresh matching on and off");
      if (error_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/dmbm_pkg.sv
hw/rtl/dmbm_if.sv
hw/rtl/dmbm_div.sv
hw/rtl/dmbm_csr.sv
hw/rtl/display_mode_best_match.sv
dv/testbench.sv
